>>> sv/fpu_pkg.sv
`default_nettype none

package fpu_pkg;

    // scaling constants
    localparam int unsigned SCALE_DIV       = 100;
    localparam int unsigned SCALE_MAX       = 799;
    localparam int unsigned SCALE_RESET     = 100;
    localparam int unsigned CLIP_W_RESET    = 317;
    localparam int unsigned CLIP_H_RESET    = 377;
    localparam logic [7:0]  TRANSPARENT     = 8'hff;

    // defaults for the top level parameters
    localparam int unsigned COORD_BITS_DEF  = 12;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // fixed field widths
    localparam int unsigned POS_W   = 11;
    localparam int unsigned PIX_W   = 8;
    localparam int unsigned CFG_W   = 12;
    localparam int unsigned CFG_IDX = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX-1:0] {
        CFG_SCALE    = 3'd0,
        CFG_X_ORIGIN = 3'd1,
        CFG_Y_ORIGIN = 3'd2,
        CFG_SEED     = 3'd3,
        CFG_CLIP_EN  = 3'd4,
        CFG_CLIP_W   = 3'd5,
        CFG_CLIP_H   = 3'd6,
        CFG_SKIP     = 3'd7
    } cfg_reg_t;

    // whole factor and remainder of the scale
    typedef struct packed {
        logic [2:0] q;
        logic [6:0] r;
    } scale_split_t;

    // one surviving block of writes, inclusive corners
    typedef struct packed {
        logic [POS_W-1:0] x0;
        logic [POS_W-1:0] x1;
        logic [POS_W-1:0] y0;
        logic [POS_W-1:0] y1;
        logic [PIX_W-1:0] value;
    } fpu_desc_t;

    // queue status towards front and back
    typedef struct packed {
        logic full;
        logic empty;
    } fpu_q_stat_t;

    // split a scale in percent into q and r, saturating at the top of the range
    function automatic scale_split_t scale_split(input logic [9:0] s);
        logic [9:0]   sc;
        logic [2:0]   q;
        scale_split_t res;
        sc = (s > 10'(SCALE_MAX)) ? 10'(SCALE_MAX) : s;
        q  = 3'd0;
        for (int k = 1; k < 8; k++)
        begin
            if (sc >= 10'(k * SCALE_DIV))
            begin
                q = 3'(k);
            end
        end
        res.q = q;
        res.r = 7'(sc - 10'(q) * 10'(SCALE_DIV));
        return res;
    endfunction

endpackage

`default_nettype wire

>>> sv/fpu_front.sv
`default_nettype none

module fpu_front #(
    parameter int unsigned COORD_BITS = fpu_pkg::COORD_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr,
    input  wire logic [fpu_pkg::CFG_IDX-1:0] cfg_index,
    input  wire logic [fpu_pkg::CFG_W-1:0]   cfg_data,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,  // pixel
    input  wire logic                        s_tlast,  // row_end
    input  wire fpu_pkg::fpu_q_stat_t        q_stat,
    output logic                             q_push,
    output fpu_pkg::fpu_desc_t               q_data
);

    localparam int CW    = COORD_BITS + 1;
    localparam int EW    = COORD_BITS + 2;
    localparam int W     = (EW > 13) ? EW : 13;
    localparam int LIM   = (COORD_BITS >= 12) ? 2048 : (1 << (COORD_BITS - 1));
    localparam int CMAX  = (1 << COORD_BITS) - 1;
    localparam int CMIN  = -(1 << COORD_BITS);

    // clamp a 12 bit origin into the cursor range
    function automatic logic signed [CW-1:0] clamp_origin(input logic signed [11:0] v);
        logic signed [W-1:0] ext;
        logic signed [W-1:0] res;
        ext = W'(v);
        res = ext;
        if (ext > W'(CMAX))
        begin
            res = W'(CMAX);
        end
        if (ext < W'(CMIN))
        begin
            res = W'(CMIN);
        end
        return CW'(res);
    endfunction

    // configuration registers
    fpu_pkg::scale_split_t      split_reg, split_next;
    logic signed [11:0]         x_origin_reg, x_origin_next;
    logic signed [11:0]         y_origin_reg, y_origin_next;
    logic [6:0]                 seed_reg, seed_next;
    logic                       clip_en_reg, clip_en_next;
    logic [10:0]                clip_w_reg, clip_w_next;
    logic [10:0]                clip_h_reg, clip_h_next;
    logic                       skip_reg, skip_next;
    logic                       restart;

    // walk state
    logic signed [CW-1:0]       cursor_x_reg, cursor_x_next;
    logic signed [CW-1:0]       row_y_reg, row_y_next;
    logic [6:0]                 accum_x_reg, accum_x_next;
    logic [6:0]                 accum_y_reg, accum_y_next;

    // per pixel block geometry
    logic                       accept;
    logic [11:0]                xlim12, ylim12;
    logic signed [EW-1:0]       xlim, ylim;
    logic [7:0]                 sx, sy;
    logic                       carry_x, carry_y;
    logic [3:0]                 ncols, nrows;
    logic signed [EW-1:0]       cur_x_e, cur_y_e;
    logic signed [EW-1:0]       x_sum, y_sum;
    logic signed [EW-1:0]       x_start, y_start, x_end, y_end;
    logic                       drop_px, block_ok;

    // config write decode
    always_comb
    begin
        split_next    = split_reg;
        x_origin_next = x_origin_reg;
        y_origin_next = y_origin_reg;
        seed_next     = seed_reg;
        clip_en_next  = clip_en_reg;
        clip_w_next   = clip_w_reg;
        clip_h_next   = clip_h_reg;
        skip_next     = skip_reg;
        restart       = 1'b0;
        if (cfg_wr)
        begin
            restart = 1'b1;
            case (fpu_pkg::cfg_reg_t'(cfg_index))
                fpu_pkg::CFG_SCALE:    split_next    = fpu_pkg::scale_split(cfg_data[9:0]);
                fpu_pkg::CFG_X_ORIGIN: x_origin_next = cfg_data;
                fpu_pkg::CFG_Y_ORIGIN: y_origin_next = cfg_data;
                fpu_pkg::CFG_SEED:     seed_next     = cfg_data[6:0];
                fpu_pkg::CFG_CLIP_EN:  clip_en_next  = cfg_data[0];
                fpu_pkg::CFG_CLIP_W:   clip_w_next   = cfg_data[10:0];
                fpu_pkg::CFG_CLIP_H:   clip_h_next   = cfg_data[10:0];
                fpu_pkg::CFG_SKIP:     skip_next     = cfg_data[0];
                default:               restart       = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_reg    <= fpu_pkg::scale_split(10'(fpu_pkg::SCALE_RESET));
            x_origin_reg <= '0;
            y_origin_reg <= '0;
            seed_reg     <= '0;
            clip_en_reg  <= 1'b0;
            clip_w_reg   <= 11'(fpu_pkg::CLIP_W_RESET);
            clip_h_reg   <= 11'(fpu_pkg::CLIP_H_RESET);
            skip_reg     <= 1'b0;
        end
        else
        begin
            split_reg    <= split_next;
            x_origin_reg <= x_origin_next;
            y_origin_reg <= y_origin_next;
            seed_reg     <= seed_next;
            clip_en_reg  <= clip_en_next;
            clip_w_reg   <= clip_w_next;
            clip_h_reg   <= clip_h_next;
            skip_reg     <= skip_next;
        end
    end

    // upper bounds, exclusive, of the writable window
    always_comb
    begin
        xlim12 = 12'(LIM);
        ylim12 = 12'(LIM);
        if (clip_en_reg && ({1'b0, clip_w_reg} < 12'(LIM)))
        begin
            xlim12 = {1'b0, clip_w_reg};
        end
        if (clip_en_reg && ({1'b0, clip_h_reg} < 12'(LIM)))
        begin
            ylim12 = {1'b0, clip_h_reg};
        end
        xlim = EW'(signed'({1'b0, xlim12}));
        ylim = EW'(signed'({1'b0, ylim12}));
    end

    // block size from the remainder accumulators
    always_comb
    begin
        sx      = {1'b0, accum_x_reg} + {1'b0, split_reg.r};
        sy      = {1'b0, accum_y_reg} + {1'b0, split_reg.r};
        carry_x = (sx >= 8'(fpu_pkg::SCALE_DIV));
        carry_y = (sy >= 8'(fpu_pkg::SCALE_DIV));
        ncols   = {1'b0, split_reg.q} + {3'b000, carry_x};
        nrows   = {1'b0, split_reg.q} + {3'b000, carry_y};
    end

    // surviving rectangle of the block
    always_comb
    begin
        cur_x_e  = EW'(cursor_x_reg);
        cur_y_e  = EW'(row_y_reg);
        x_sum    = cur_x_e + EW'(signed'({1'b0, ncols}));
        y_sum    = cur_y_e + EW'(signed'({1'b0, nrows}));
        x_start  = cur_x_e[EW-1] ? EW'(0) : cur_x_e;
        y_start  = cur_y_e[EW-1] ? EW'(0) : cur_y_e;
        x_end    = (x_sum < xlim) ? x_sum : xlim;
        y_end    = (y_sum < ylim) ? y_sum : ylim;
        drop_px  = skip_reg && (s_tdata == fpu_pkg::TRANSPARENT);
        block_ok = !drop_px && (x_start < x_end) && (y_start < y_end);
    end

    // next walk state
    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        row_y_next    = row_y_reg;
        accum_x_next  = accum_x_reg;
        accum_y_next  = accum_y_reg;
        if (restart)
        begin
            cursor_x_next = clamp_origin(x_origin_next);
            row_y_next    = clamp_origin(y_origin_next);
            accum_x_next  = seed_next;
            accum_y_next  = seed_next;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                cursor_x_next = clamp_origin(x_origin_reg);
                accum_x_next  = seed_reg;
                row_y_next    = (y_sum > EW'(CMAX)) ? CW'(CMAX) : CW'(y_sum);
                accum_y_next  = carry_y ? 7'(sy - 8'(fpu_pkg::SCALE_DIV)) : sy[6:0];
            end
            else
            begin
                cursor_x_next = (x_sum > EW'(CMAX)) ? CW'(CMAX) : CW'(x_sum);
                accum_x_next  = carry_x ? 7'(sx - 8'(fpu_pkg::SCALE_DIV)) : sx[6:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= '0;
            row_y_reg    <= '0;
            accum_x_reg  <= '0;
            accum_y_reg  <= '0;
        end
        else
        begin
            cursor_x_reg <= cursor_x_next;
            row_y_reg    <= row_y_next;
            accum_x_reg  <= accum_x_next;
            accum_y_reg  <= accum_y_next;
        end
    end

    // handshake and queue push
    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept && block_ok;

    always_comb
    begin
        q_data.x0    = fpu_pkg::POS_W'(x_start);
        q_data.x1    = fpu_pkg::POS_W'(x_end - EW'(1));
        q_data.y0    = fpu_pkg::POS_W'(y_start);
        q_data.y1    = fpu_pkg::POS_W'(y_end - EW'(1));
        q_data.value = s_tdata;
    end

endmodule

`default_nettype wire

>>> sv/fpu_queue.sv
`default_nettype none

module fpu_queue #(
    parameter int unsigned DEPTH = fpu_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire fpu_pkg::fpu_desc_t   push_data,
    input  wire logic                 pop,
    output fpu_pkg::fpu_desc_t        pop_data,
    output fpu_pkg::fpu_q_stat_t      stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    fpu_pkg::fpu_desc_t mem_reg [DEPTH];
    logic [PW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]      count_reg, count_next;
    logic               do_push, do_pop;

    assign stat.full  = (count_reg == NW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = mem_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> sv/fpu_back.sv
`default_nettype none

module fpu_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fpu_pkg::fpu_q_stat_t q_stat,
    input  wire fpu_pkg::fpu_desc_t   q_data,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [31:0]               m_tdata,  // dest_x, dest_y, value, zero pad
    output logic                      m_tlast   // last
);

    localparam int PW = fpu_pkg::POS_W;

    // block walk registers
    logic                       busy_reg, busy_next;
    logic [PW-1:0]              cx_reg, cx_next;
    logic [PW-1:0]              cy_reg, cy_next;
    logic [PW-1:0]              x0_reg, x0_next;
    logic [PW-1:0]              x1_reg, x1_next;
    logic [PW-1:0]              y1_reg, y1_next;
    logic [fpu_pkg::PIX_W-1:0]  val_reg, val_next;

    // output beat registers
    logic                       ovalid_reg, ovalid_next;
    logic [PW-1:0]              ox_reg, ox_next;
    logic [PW-1:0]              oy_reg, oy_next;
    logic [fpu_pkg::PIX_W-1:0]  oval_reg, oval_next;
    logic                       olast_reg, olast_next;

    logic                       adv, is_last;

    assign adv     = busy_reg && (!ovalid_reg || m_tready);
    assign is_last = (cx_reg == x1_reg) && (cy_reg == y1_reg);
    assign q_pop   = !q_stat.empty && (!busy_reg || (adv && is_last));

    // walk columns inner, rows outer
    always_comb
    begin
        busy_next = busy_reg;
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        x0_next   = x0_reg;
        x1_next   = x1_reg;
        y1_next   = y1_reg;
        val_next  = val_reg;
        if (adv)
        begin
            if (cx_reg == x1_reg)
            begin
                cx_next = x0_reg;
                cy_next = cy_reg + PW'(1);
            end
            else
            begin
                cx_next = cx_reg + PW'(1);
            end
            if (is_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (q_pop)
        begin
            busy_next = 1'b1;
            cx_next   = q_data.x0;
            cy_next   = q_data.y0;
            x0_next   = q_data.x0;
            x1_next   = q_data.x1;
            y1_next   = q_data.y1;
            val_next  = q_data.value;
        end
    end

    // output register, refilled as the beat leaves
    always_comb
    begin
        ovalid_next = ovalid_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        oval_next   = oval_reg;
        olast_next  = olast_reg;
        if (adv)
        begin
            ovalid_next = 1'b1;
            ox_next     = cx_reg;
            oy_next     = cy_reg;
            oval_next   = val_reg;
            olast_next  = is_last;
        end
        else if (m_tready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        x0_reg    <= x0_next;
        x1_reg    <= x1_next;
        y1_reg    <= y1_next;
        val_reg   <= val_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        oval_reg  <= oval_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {2'b00, oval_reg, oy_reg, ox_reg};
    assign m_tlast  = olast_reg;

    // walk stays inside the loaded rectangle
    a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cx_reg >= x0_reg && cx_reg <= x1_reg && cy_reg <= y1_reg))
        else $error("block walk left its rectangle");

    // a loaded block is never empty
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (busy_reg && cx_reg <= x1_reg && cy_reg <= y1_reg))
        else $error("loaded block has no writes");

    // the final beat of a block ends the walk unless a new block loads
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && is_last && !q_pop) |=> (!busy_reg && ovalid_reg && olast_reg))
        else $error("walk continued past the final write");

endmodule

`default_nettype wire

>>> sv/fractional_pixel_upscaler.sv
`default_nettype none

// channel   dir  beat content                                   accepted when
// s_axis    in   tdata[7:0] pixel, tlast row_end                 s_tvalid & s_tready
// m_axis    out  tdata dest_x, dest_y, value; tlast last         m_tvalid & m_tready
// cfg       in   cfg_index register, cfg_data value              cfg_wr
//
// the front takes one pixel a cycle while the descriptor queue has room
// the back emits one write per cycle from its column and row counter while the
// output is not stalled; a pixel yields at most 64 writes
// reset is asynchronous and immediate; there is no clearing pass
// a stalled output holds its beat in the output register while the back
// loads the next write behind it and the front keeps filling the queue

module fractional_pixel_upscaler #(
    parameter int unsigned COORD_BITS  = fpu_pkg::COORD_BITS_DEF,
    parameter int unsigned QUEUE_DEPTH = fpu_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr,
    input  wire logic [fpu_pkg::CFG_IDX-1:0] cfg_index,
    input  wire logic [fpu_pkg::CFG_W-1:0]   cfg_data,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,  // pixel
    input  wire logic                        s_tlast,  // row_end
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [31:0]                      m_tdata,  // dest_x, dest_y, value, zero pad
    output logic                             m_tlast   // last
);

    fpu_pkg::fpu_q_stat_t q_stat;
    fpu_pkg::fpu_desc_t   push_data;
    fpu_pkg::fpu_desc_t   pop_data;
    logic                 q_push;
    logic                 q_pop;

    // pixel classification and block geometry
    fpu_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_data    (push_data)
    );

    // descriptor queue
    fpu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    // write generation
    fpu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .q_data   (pop_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int CB            = fpu_pkg::COORD_BITS_DEF;
    localparam int CW            = CB + 1;
    localparam int COORD_HI      = (1 << CB) - 1;
    localparam int COORD_LO      = -(1 << CB);
    localparam int COORD_LIM     = (CB >= 12) ? 2048 : (1 << (CB - 1));
    localparam int DRAIN_CYCLES  = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 40;
    localparam int LONG_ROW      = 264;
    localparam int SQUEEZE_ITEMS = 20;

    // one frame-buffer write, as carried on the output beat
    typedef struct packed {
        logic [fpu_pkg::POS_W-1:0] x;
        logic [fpu_pkg::POS_W-1:0] y;
        logic [fpu_pkg::PIX_W-1:0] value;
        logic                      last;
    } write_t;

    // one line of the directed sequence: a register write or a pixel
    typedef struct packed {
        bit                        is_cfg;
        fpu_pkg::cfg_reg_t         idx;
        logic [fpu_pkg::CFG_W-1:0] data;
        logic [fpu_pkg::PIX_W-1:0] pix;
        logic                      row_end;
        bit                        known;
        bit                        known_has;
        write_t                    known_w;
    } stim_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_wr;
    logic [fpu_pkg::CFG_IDX-1:0] cfg_index;
    logic [fpu_pkg::CFG_W-1:0]   cfg_data;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [7:0]                  s_tdata;
    logic                        s_tlast;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [31:0]                 m_tdata;
    logic                        m_tlast;

    // expectation typed into the directed sequence, travels with its beat
    logic               known_row;
    logic               known_has;
    write_t             known_write;

    write_t             writes_due[$];
    stim_row_t          directed[$];
    int                 fail_count  = 0;
    int                 quiet_cycles = 0;
    int                 pixels_in   = 0;
    int                 gap_odds    = 0;
    bit                 calm        = 1'b0;
    bit                 squeeze     = 1'b0;
    bit                 held_off    = 1'b0;

    // registers as the block should hold them
    logic [9:0]                scale_pct;
    logic signed [11:0]        x_org;
    logic signed [11:0]        y_org;
    logic [6:0]                seed;
    logic                      clip_on;
    logic [fpu_pkg::POS_W-1:0] clip_w;
    logic [fpu_pkg::POS_W-1:0] clip_h;
    logic                      skip_ff;

    // walking state of the upscaler
    logic signed [CB:0] cursor_x;
    logic signed [CB:0] row_y;
    logic [6:0]         acc_x;
    logic [6:0]         acc_y;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    fractional_pixel_upscaler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    function automatic int saturate_coord(input int v);
        if (v > COORD_HI)
        begin
            return COORD_HI;
        end
        if (v < COORD_LO)
        begin
            return COORD_LO;
        end
        return v;
    endfunction

    // cursor and accumulators back to the origin
    function void rewind_cursor();
        cursor_x = CW'(saturate_coord(int'(x_org)));
        acc_x    = seed;
        row_y    = CW'(saturate_coord(int'(y_org)));
        acc_y    = seed;
    endfunction

    function void load_register(input fpu_pkg::cfg_reg_t idx,
                                input logic [fpu_pkg::CFG_W-1:0] d);
        case (idx)
            fpu_pkg::CFG_SCALE:    scale_pct = d[9:0];
            fpu_pkg::CFG_X_ORIGIN: x_org     = d;
            fpu_pkg::CFG_Y_ORIGIN: y_org     = d;
            fpu_pkg::CFG_SEED:     seed      = d[6:0];
            fpu_pkg::CFG_CLIP_EN:  clip_on   = d[0];
            fpu_pkg::CFG_CLIP_W:   clip_w    = d[fpu_pkg::POS_W-1:0];
            fpu_pkg::CFG_CLIP_H:   clip_h    = d[fpu_pkg::POS_W-1:0];
            fpu_pkg::CFG_SKIP:     skip_ff   = d[0];
            default:               ;
        endcase
        rewind_cursor();
    endfunction

    // block of writes for one pixel, rows outer and columns inner
    function void upscale_pixel(input logic [7:0] pix, input logic row_end, input bit keep);
        int     s;
        int     q;
        int     r;
        int     sx;
        int     sy;
        int     ncols;
        int     nrows;
        int     x;
        int     y;
        bit     drop;
        bit     have;
        write_t w;
        write_t held_w;
        s     = (scale_pct > fpu_pkg::SCALE_MAX) ? fpu_pkg::SCALE_MAX : scale_pct;
        q     = s / fpu_pkg::SCALE_DIV;
        r     = s % fpu_pkg::SCALE_DIV;
        sx    = acc_x + r;
        sy    = acc_y + r;
        ncols = q + ((sx >= fpu_pkg::SCALE_DIV) ? 1 : 0);
        nrows = q + ((sy >= fpu_pkg::SCALE_DIV) ? 1 : 0);
        drop  = skip_ff && (pix == fpu_pkg::TRANSPARENT);
        have  = 1'b0;
        for (int i = 0; i < nrows; i++)
        begin
            for (int j = 0; j < ncols; j++)
            begin
                x = cursor_x + j;
                y = row_y + i;
                if (drop || x < 0 || x >= COORD_LIM || y < 0 || y >= COORD_LIM)
                begin
                    continue;
                end
                if (clip_on && (x >= clip_w || y >= clip_h))
                begin
                    continue;
                end
                w.x     = x[fpu_pkg::POS_W-1:0];
                w.y     = y[fpu_pkg::POS_W-1:0];
                w.value = pix;
                w.last  = 1'b0;
                if (have && keep)
                begin
                    writes_due.push_back(held_w);
                end
                held_w = w;
                have   = 1'b1;
            end
        end
        if (have && keep)
        begin
            held_w.last = 1'b1;
            writes_due.push_back(held_w);
        end
        cursor_x = CW'(saturate_coord(cursor_x + ncols));
        acc_x    = 7'((sx >= fpu_pkg::SCALE_DIV) ? sx - fpu_pkg::SCALE_DIV : sx);
        if (row_end)
        begin
            cursor_x = CW'(saturate_coord(int'(x_org)));
            acc_x    = seed;
            row_y    = CW'(saturate_coord(row_y + nrows));
            acc_y    = 7'((sy >= fpu_pkg::SCALE_DIV) ? sy - fpu_pkg::SCALE_DIV : sy);
        end
    endfunction

    task report_mismatch(input string what);
        $display("%0d ns  mismatch: %s", $time, what);
        fail_count++;
    endtask

    function void add_cfg(input fpu_pkg::cfg_reg_t idx, input logic [fpu_pkg::CFG_W-1:0] d);
        stim_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = d;
        directed.push_back(row);
    endfunction

    function void add_pix(input logic [7:0] pix, input logic re);
        stim_row_t row;
        row         = '0;
        row.pix     = pix;
        row.row_end = re;
        directed.push_back(row);
    endfunction

    // pixel whose outcome is plain to see: one write or none
    function void add_known(input logic [7:0] pix, input logic re, input bit has,
                            input int x, input int y);
        stim_row_t row;
        row               = '0;
        row.pix           = pix;
        row.row_end       = re;
        row.known         = 1'b1;
        row.known_has     = has;
        row.known_w.x     = x[fpu_pkg::POS_W-1:0];
        row.known_w.y     = y[fpu_pkg::POS_W-1:0];
        row.known_w.value = pix;
        row.known_w.last  = 1'b1;
        directed.push_back(row);
    endfunction

    // offer one pixel beat and hold it until taken, then maybe a gap
    task send_pixel(input logic [7:0] pix, input logic re, input bit known,
                    input bit has, input write_t w);
        s_tvalid    <= 1'b1;
        s_tdata     <= pix;
        s_tlast     <= re;
        known_row   <= known;
        known_has   <= has;
        known_write <= w;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task write_reg(input fpu_pkg::cfg_reg_t idx, input logic [fpu_pkg::CFG_W-1:0] d);
        cfg_wr    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        cfg_wr    <= 1'b0;
        @(posedge clk);
    endtask

    // stop offering, let every expected write out, then let the pipe settle
    task wait_idle();
        s_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (writes_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // predictor reset state
    initial
    begin
        scale_pct = 10'(fpu_pkg::SCALE_RESET);
        x_org     = '0;
        y_org     = '0;
        seed      = '0;
        clip_on   = 1'b0;
        clip_w    = fpu_pkg::POS_W'(fpu_pkg::CLIP_W_RESET);
        clip_h    = fpu_pkg::POS_W'(fpu_pkg::CLIP_H_RESET);
        skip_ff   = 1'b0;
        rewind_cursor();
    end

    // beat monitor: checks writes, tracks registers, predicts from pixels
    always @(posedge clk)
    begin : monitor
        write_t got;
        write_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.x     = m_tdata[10:0];
                got.y     = m_tdata[21:11];
                got.value = m_tdata[29:22];
                got.last  = m_tlast;
                if (writes_due.size() == 0)
                begin
                    report_mismatch($sformatf("write x %0d y %0d value %02h last %0d not expected",
                        got.x, got.y, got.value, got.last));
                end
                else
                begin
                    want = writes_due.pop_front();
                    if (got.x != want.x || got.y != want.y || got.value != want.value ||
                        got.last != want.last)
                    begin
                        report_mismatch($sformatf(
                            "write x %0d y %0d value %02h last %0d, wanted %0d %0d %02h %0d",
                            got.x, got.y, got.value, got.last,
                            want.x, want.y, want.value, want.last));
                    end
                end
            end
            if (cfg_wr)
            begin
                load_register(fpu_pkg::cfg_reg_t'(cfg_index), cfg_data);
            end
            if (s_tvalid && s_tready)
            begin
                pixels_in++;
                if (known_row)
                begin
                    upscale_pixel(s_tdata, s_tlast, 1'b0);
                    if (known_has)
                    begin
                        writes_due.push_back(known_write);
                    end
                end
                else
                begin
                    upscale_pixel(s_tdata, s_tlast, 1'b1);
                end
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || cfg_wr)
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
    end

    // watchdog on cycles without any beat
    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // output side: random stalls, one long hold-off during the burst
    initial
    begin : receiver
        m_tready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!held_off && squeeze)
            begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // stimulus
    initial
    begin : driver
        stim_row_t                 row;
        write_t                    no_write;
        logic [fpu_pkg::CFG_W-1:0] d;
        logic [7:0]                pix;
        logic                      re;
        bit                        prev_cfg;
        int                        rows;
        int                        len;
        int                        pick;
        int                        phase;
        int                        sent;

        rst_n       <= 1'b0;
        cfg_wr      <= 1'b0;
        cfg_index   <= fpu_pkg::CFG_SCALE;
        cfg_data    <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tlast     <= 1'b0;
        known_row   <= 1'b0;
        known_has   <= 1'b0;
        known_write <= '0;
        no_write    = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset values, transparency, scale extremes, fractions,
        // seeds beyond 99, coordinates off range, clipping and its widest window
        add_known(8'h00, 1'b0, 1'b1, 0, 0);
        add_known(8'hff, 1'b0, 1'b1, 1, 0);
        add_known(8'ha5, 1'b1, 1'b1, 2, 0);
        add_known(8'h5a, 1'b0, 1'b1, 0, 1);
        add_cfg(fpu_pkg::CFG_SKIP, 12'h001);
        add_known(fpu_pkg::TRANSPARENT, 1'b0, 1'b0, 0, 0);
        add_known(8'h01, 1'b1, 1'b1, 1, 0);
        add_cfg(fpu_pkg::CFG_SKIP, 12'h000);
        add_cfg(fpu_pkg::CFG_SCALE, 12'd799);
        add_pix(8'h3c, 1'b1);
        add_cfg(fpu_pkg::CFG_SCALE, 12'h3ff);
        add_pix(8'hc3, 1'b0);
        add_cfg(fpu_pkg::CFG_SCALE, 12'd0);
        add_known(8'h77, 1'b1, 1'b0, 0, 0);
        add_cfg(fpu_pkg::CFG_SCALE, 12'd50);
        add_cfg(fpu_pkg::CFG_SEED, 12'd99);
        add_pix(8'h11, 1'b0);
        add_pix(8'h22, 1'b0);
        add_pix(8'h33, 1'b1);
        add_pix(8'h44, 1'b0);
        add_cfg(fpu_pkg::CFG_SEED, 12'd127);
        add_cfg(fpu_pkg::CFG_SCALE, 12'd150);
        add_pix(8'h55, 1'b0);
        add_pix(8'h66, 1'b1);
        add_cfg(fpu_pkg::CFG_SCALE, 12'd100);
        add_cfg(fpu_pkg::CFG_SEED, 12'd0);
        add_cfg(fpu_pkg::CFG_X_ORIGIN, 12'h800);
        add_known(8'h99, 1'b0, 1'b0, 0, 0);
        add_cfg(fpu_pkg::CFG_X_ORIGIN, 12'h7ff);
        add_cfg(fpu_pkg::CFG_Y_ORIGIN, 12'hfff);
        add_cfg(fpu_pkg::CFG_SCALE, 12'd200);
        add_known(8'h12, 1'b1, 1'b1, 2047, 0);
        add_pix(8'h34, 1'b0);
        add_cfg(fpu_pkg::CFG_Y_ORIGIN, 12'h7ff);
        add_cfg(fpu_pkg::CFG_X_ORIGIN, 12'h000);
        add_cfg(fpu_pkg::CFG_SCALE, 12'd300);
        add_pix(8'h56, 1'b1);
        add_cfg(fpu_pkg::CFG_CLIP_EN, 12'h001);
        add_cfg(fpu_pkg::CFG_CLIP_W, 12'd2);
        add_cfg(fpu_pkg::CFG_CLIP_H, 12'd1);
        add_cfg(fpu_pkg::CFG_Y_ORIGIN, 12'h000);
        add_pix(8'h78, 1'b0);
        add_known(8'h9a, 1'b1, 1'b0, 0, 0);
        add_cfg(fpu_pkg::CFG_CLIP_W, 12'hfff);
        add_cfg(fpu_pkg::CFG_CLIP_H, 12'h7ff);
        add_pix(8'hbc, 1'b0);

        gap_odds = 4;
        prev_cfg = 1'b0;
        for (int k = 0; k < directed.size(); k++)
        begin
            row = directed[k];
            if (row.is_cfg)
            begin
                if (!prev_cfg)
                begin
                    wait_idle();
                end
                write_reg(row.idx, row.data);
            end
            else
            begin
                send_pixel(row.pix, row.row_end, row.known, row.known_has, row.known_w);
            end
            prev_cfg = row.is_cfg;
        end

        // steady burst against a held-off receiver, the queue fills and the input stalls
        wait_idle();
        write_reg(fpu_pkg::CFG_SCALE, 12'd200);
        gap_odds = 0;
        squeeze  = 1'b1;
        for (int k = 0; k < SQUEEZE_ITEMS; k++)
        begin
            send_pixel(8'($urandom), 1'b0, 1'b0, 1'b0, no_write);
        end

        // one very long row at the right edge drives the cursor into saturation
        wait_idle();
        write_reg(fpu_pkg::CFG_SCALE, 12'd799);
        write_reg(fpu_pkg::CFG_X_ORIGIN, 12'h7ff);
        write_reg(fpu_pkg::CFG_Y_ORIGIN, 12'h000);
        write_reg(fpu_pkg::CFG_CLIP_EN, 12'h000);
        write_reg(fpu_pkg::CFG_SKIP, 12'h000);
        gap_odds = 0;
        for (int k = 0; k < LONG_ROW; k++)
        begin
            send_pixel(8'($urandom), k == LONG_ROW - 1, 1'b0, 1'b0, no_write);
        end

        // random images, fresh settings between them
        phase     = 0;
        sent      = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_idle();
            if (sent >= RANDOM_ITEMS - 20)
            begin
                calm = 1'b1;
            end
            for (int k = 0; k < 8; k++)
            begin
                if (phase == 0 || $urandom_range(0, 2) == 0)
                begin
                    d    = 12'($urandom);
                    pick = $urandom_range(0, 9);
                    case (fpu_pkg::cfg_reg_t'(k))
                        fpu_pkg::CFG_SCALE:
                        begin
                            if (pick < 6)
                            begin
                                d[9:0] = 10'($urandom_range(100, 300));
                            end
                            else if (pick == 6)
                            begin
                                d[9:0] = 10'($urandom_range(0, 99));
                            end
                            else if (pick == 7)
                            begin
                                d[9:0] = 10'($urandom_range(700, 799));
                            end
                            else if (pick == 8)
                            begin
                                d[9:0] = 10'($urandom_range(800, 1023));
                            end
                        end
                        fpu_pkg::CFG_X_ORIGIN, fpu_pkg::CFG_Y_ORIGIN:
                        begin
                            if (pick < 7)
                            begin
                                d = 12'($urandom_range(0, 40) - 8);
                            end
                            else if (pick < 9)
                            begin
                                d = 12'($urandom_range(2030, 2047));
                            end
                        end
                        fpu_pkg::CFG_CLIP_W, fpu_pkg::CFG_CLIP_H:
                        begin
                            if (pick < 6)
                            begin
                                d[10:0] = 11'($urandom_range(0, 48));
                            end
                        end
                        default: ;
                    endcase
                    write_reg(fpu_pkg::cfg_reg_t'(k), d);
                end
            end
            gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
            rows     = $urandom_range(1, 6);
            for (int r = 0; r < rows; r++)
            begin
                len = $urandom_range(1, 10);
                for (int c = 0; c < len; c++)
                begin
                    pick = $urandom_range(0, 9);
                    pix  = (pick < 2) ? fpu_pkg::TRANSPARENT :
                           (pick == 2) ? 8'h00 : 8'($urandom);
                    // the last row of an image is sometimes left open
                    re   = (c == len - 1) && !(r == rows - 1 && $urandom_range(0, 3) == 0);
                    send_pixel(pix, re, 1'b0, 1'b0, no_write);
                    sent++;
                end
            end
            phase++;
        end

        wait_idle();
        if (fail_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/fpu_pkg.sv
sv/fpu_front.sv
sv/fpu_queue.sv
sv/fpu_back.sv
sv/fractional_pixel_upscaler.sv
dv/tb_top.sv
